// ===== sv/trilinear_grid_sampler_macros.svh =====
// Assertion macros shared by the trilinear grid sampler RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TRILINEAR_GRID_SAMPLER_MACROS_SVH
`define TRILINEAR_GRID_SAMPLER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TGS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define TGS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/tgs_pkg.sv =====
// Package of the trilinear grid sampler: widths, command types, rounding helper.
// No dependencies; imported by every module of the block.
package tgs_pkg;

    localparam int GRID_N_DEF      = 64;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int FRAC_W          = 20;
    localparam int COORD_W         = 24;
    localparam int VAL_W           = 24;
    localparam int CELL_W          = 6;
    localparam int IDX_W           = 7;
    localparam int S_W             = 32;
    localparam int W_W             = 22;
    localparam int C_W             = 32;
    localparam int P_W             = C_W + W_W;
    localparam int OUT_W           = 36;
    localparam int MILLI_Q20       = 1049;
    localparam int IN_TDATA_W      = 120;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic {
        KIND_WRITE,
        KIND_QUERY
    } t_kind;

    // One classified item. Writes use the index fields as the cell address.
    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         ix;
        logic [IDX_W-1:0]         iy;
        logic [IDX_W-1:0]         iz;
        logic signed [W_W-1:0]    wx;
        logic signed [W_W-1:0]    wy;
        logic signed [W_W-1:0]    wz;
        logic                     outside;
        logic signed [OUT_W-1:0]  penalty;
        logic signed [VAL_W-1:0]  value;
    } t_cmd;

    // Per-axis classification of a query coordinate.
    typedef struct packed {
        logic                   neg;
        logic                   inner;
        logic [IDX_W-1:0]       idx;
        logic signed [W_W-1:0]  w;
        logic signed [S_W-1:0]  pen;
    } t_axis;

    // Queue status seen by the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Rounds a Q.40 sum to Q.20, to nearest with ties toward +infinity.
    function automatic logic signed [C_W-1:0] round_q20(input logic signed [P_W:0] v);
        logic signed [P_W:0] t;
        t = v + (P_W+1)'(1 << (FRAC_W - 1));
        return t[FRAC_W +: C_W];
    endfunction

endpackage

// ===== sv/tgs_front.sv =====
// Front end of the trilinear grid sampler: unpacks and classifies input items.
// Depends on tgs_pkg.
module tgs_front import tgs_pkg::*; #(
    parameter int GRID_N = GRID_N_DEF
) (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    localparam logic signed [S_W-1:0] ONE     = S_W'(1 << FRAC_W);
    localparam logic signed [S_W-1:0] LIM_IN  = S_W'((GRID_N - 1) << FRAC_W);
    localparam logic signed [S_W-1:0] LIM_HI  = S_W'(GRID_N << FRAC_W);
    localparam logic signed [S_W-1:0] PEN_OFS = S_W'(((GRID_N - 1) << FRAC_W) - MILLI_Q20);

    logic [CELL_W-1:0]         cell_x, cell_y, cell_z;
    logic signed [VAL_W-1:0]   cell_value;
    logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
    t_axis                     ax, ay, az;
    logic                      wr_ok;

    // Scale by the grid size, truncate toward zero, and work out the weight
    // and this axis' share of the outside penalty.
    function automatic t_axis classify(input logic signed [COORD_W-1:0] c);
        logic signed [S_W-1:0] s;
        logic                  hi;
        t_axis                 a;
        s       = S_W'(c) * S_W'(GRID_N);
        hi      = s >= LIM_HI;
        a.neg   = s <= -ONE;
        a.inner = !a.neg && (s < LIM_IN);
        a.idx   = s[S_W-1] ? '0 : s[FRAC_W +: IDX_W];
        a.w     = s[S_W-1] ? s[W_W-1:0] : {2'b00, s[FRAC_W-1:0]};
        if (a.neg) begin
            a.pen = -s;
        end else if (hi) begin
            a.pen = s - PEN_OFS;
        end else begin
            a.pen = '0;
        end
        return a;
    endfunction

    assign cell_x     = s_axis_tdata[5:0];
    assign cell_y     = s_axis_tdata[11:6];
    assign cell_z     = s_axis_tdata[17:12];
    assign cell_value = s_axis_tdata[41:18];
    assign coord_x    = s_axis_tdata[65:42];
    assign coord_y    = s_axis_tdata[89:66];
    assign coord_z    = s_axis_tdata[113:90];

    assign ax = classify(coord_x);
    assign ay = classify(coord_y);
    assign az = classify(coord_z);

    assign wr_ok = ({2'b00, cell_x} < 8'(GRID_N)) && ({2'b00, cell_y} < 8'(GRID_N))
                && ({2'b00, cell_z} < 8'(GRID_N));

    assign s_axis_tready = !i_q_stat.full;

    // A write to a cell beyond the grid is taken and dropped.
    assign o_push = s_axis_tvalid && !i_q_stat.full && (s_axis_tuser || wr_ok);

    always_comb begin
        o_cmd       = '0;
        o_cmd.value = cell_value;
        if (s_axis_tuser) begin
            o_cmd.kind    = KIND_QUERY;
            o_cmd.ix      = ax.idx;
            o_cmd.iy      = ay.idx;
            o_cmd.iz      = az.idx;
            o_cmd.wx      = ax.w;
            o_cmd.wy      = ay.w;
            o_cmd.wz      = az.w;
            o_cmd.outside = !(ax.inner && ay.inner && az.inner);
            o_cmd.penalty = OUT_W'(ax.pen) + OUT_W'(ay.pen) + OUT_W'(az.pen);
        end else begin
            o_cmd.kind = KIND_WRITE;
            o_cmd.ix   = {1'b0, cell_x};
            o_cmd.iy   = {1'b0, cell_y};
            o_cmd.iz   = {1'b0, cell_z};
        end
    end

endmodule

// ===== sv/tgs_queue.sv =====
// Short command queue between front and back end of the trilinear grid sampler.
// Depends on tgs_pkg and the assertion macros header.
`include "trilinear_grid_sampler_macros.svh"

module tgs_queue import tgs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_cmd    o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp, r_rp, n_rp;
    logic [PW:0]   r_count, n_count;

    assign o_stat.full  = r_count == (PW+1)'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rp];

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    `TGS_NEVER(a_no_overflow, i_push && o_stat.full, "push into a full queue")
    `TGS_NEVER(a_no_underflow, i_pop && o_stat.empty, "pop from an empty queue")
    `TGS_ASSERT(a_count_drop, (i_pop && !i_push) |=> (r_count == $past(r_count) - 1), "count lost a pop")

endmodule

// ===== sv/tgs_back.sv =====
// Back end of the trilinear grid sampler: eight-bank grid store and lerp pipeline.
// Depends on tgs_pkg and the assertion macros header.
`include "trilinear_grid_sampler_macros.svh"

module tgs_back import tgs_pkg::*; #(
    parameter int GRID_N = GRID_N_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_q_stat                i_q_stat,
    input  t_cmd                   i_head,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser
);

    localparam int HALF = (GRID_N + 1) / 2;
    localparam int HW   = $clog2(HALF);
    localparam int AW   = 3 * HW;
    localparam int BD   = 1 << AW;
    localparam logic signed [W_W-1:0] ONE_W = W_W'(1 << FRAC_W);

    logic adv, wr_en;

    // Stage 1: bank read data and query side data.
    logic                    r_v1, r_out1;
    logic [2:0]              r_par1;
    logic signed [W_W-1:0]   r_wx1, r_wy1, r_wz1;
    logic signed [OUT_W-1:0] r_pen1;
    logic signed [VAL_W-1:0] r_rd [8];
    logic [AW-1:0]           rd_addr [8];

    // Stage 2: x products.  Stage 3: x lerps.
    logic                    r_v2, r_out2, r_v3, r_out3;
    logic signed [P_W-1:0]   r_pa2 [4];
    logic signed [P_W-1:0]   r_pb2 [4];
    logic signed [W_W-1:0]   r_wy2, r_wz2, r_wy3, r_wz3;
    logic signed [OUT_W-1:0] r_pen2, r_pen3;
    logic signed [C_W-1:0]   r_c3 [4];

    // Stage 4: y products.  Stage 5: y lerps.
    logic                    r_v4, r_out4, r_v5, r_out5;
    logic signed [P_W-1:0]   r_pa4 [2];
    logic signed [P_W-1:0]   r_pb4 [2];
    logic signed [W_W-1:0]   r_wz4, r_wz5;
    logic signed [OUT_W-1:0] r_pen4, r_pen5;
    logic signed [C_W-1:0]   r_c5 [2];

    // Stage 6: z products.  Stage 7: output register.
    logic                    r_v6, r_out6, r_v7, r_out7;
    logic signed [P_W-1:0]   r_pa6, r_pb6;
    logic signed [OUT_W-1:0] r_pen6, r_res7;
    logic signed [C_W-1:0]   c_final;

    function automatic logic [AW-1:0] bank_addr(input logic [IDX_W-1:0] x,
                                                input logic [IDX_W-1:0] y,
                                                input logic [IDX_W-1:0] z);
        logic [IDX_W-1:0] hx, hy, hz;
        hx = x >> 1;
        hy = y >> 1;
        hz = z >> 1;
        return {hz[HW-1:0], hy[HW-1:0], hx[HW-1:0]};
    endfunction

    function automatic logic signed [P_W-1:0] mul(input logic signed [C_W-1:0] a,
                                                  input logic signed [W_W-1:0] w);
        return P_W'(a) * P_W'(w);
    endfunction

    assign adv   = !r_v7 || m_axis_tready;
    assign o_pop = adv && !i_q_stat.empty;
    assign wr_en = o_pop && (i_head.kind == KIND_WRITE);

    // Each bank holds one parity class, so the eight corners of a cell always
    // fall into eight different banks.
    for (genvar b = 0; b < 8; b++) begin : g_bank
        logic signed [VAL_W-1:0] mem [BD];
        logic [IDX_W-1:0]        cx, cy, cz;

        assign cx = i_head.ix + IDX_W'(b[0] ^ i_head.ix[0]);
        assign cy = i_head.iy + IDX_W'(b[1] ^ i_head.iy[0]);
        assign cz = i_head.iz + IDX_W'(b[2] ^ i_head.iz[0]);
        assign rd_addr[b] = bank_addr(cx, cy, cz);

        always_ff @(posedge i_clk) begin
            if (wr_en && ({i_head.iz[0], i_head.iy[0], i_head.ix[0]} == 3'(b))) begin
                mem[bank_addr(i_head.ix, i_head.iy, i_head.iz)] <= i_head.value;
            end
            if (adv) begin
                r_rd[b] <= mem[rd_addr[b]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (adv) begin
            r_v1 <= o_pop && (i_head.kind == KIND_QUERY);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign c_final = round_q20((P_W+1)'(r_pa6) + (P_W+1)'(r_pb6));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_par1 <= {i_head.iz[0], i_head.iy[0], i_head.ix[0]};
            r_wx1  <= i_head.wx;
            r_wy1  <= i_head.wy;
            r_wz1  <= i_head.wz;
            r_out1 <= i_head.outside;
            r_pen1 <= i_head.penalty;

            for (int k = 0; k < 4; k++) begin
                r_pa2[k] <= mul(C_W'(r_rd[(2*k) ^ r_par1]), ONE_W - r_wx1);
                r_pb2[k] <= mul(C_W'(r_rd[(2*k+1) ^ r_par1]), r_wx1);
            end
            r_wy2  <= r_wy1;
            r_wz2  <= r_wz1;
            r_out2 <= r_out1;
            r_pen2 <= r_pen1;

            for (int k = 0; k < 4; k++) begin
                r_c3[k] <= round_q20((P_W+1)'(r_pa2[k]) + (P_W+1)'(r_pb2[k]));
            end
            r_wy3  <= r_wy2;
            r_wz3  <= r_wz2;
            r_out3 <= r_out2;
            r_pen3 <= r_pen2;

            for (int k = 0; k < 2; k++) begin
                r_pa4[k] <= mul(r_c3[2*k], ONE_W - r_wy3);
                r_pb4[k] <= mul(r_c3[2*k+1], r_wy3);
            end
            r_wz4  <= r_wz3;
            r_out4 <= r_out3;
            r_pen4 <= r_pen3;

            for (int k = 0; k < 2; k++) begin
                r_c5[k] <= round_q20((P_W+1)'(r_pa4[k]) + (P_W+1)'(r_pb4[k]));
            end
            r_wz5  <= r_wz4;
            r_out5 <= r_out4;
            r_pen5 <= r_pen4;

            r_pa6  <= mul(r_c5[0], ONE_W - r_wz5);
            r_pb6  <= mul(r_c5[1], r_wz5);
            r_out6 <= r_out5;
            r_pen6 <= r_pen5;

            // The blend stays well inside the output range, so no clamp is hit.
            r_res7 <= r_out6 ? r_pen6 : OUT_W'(c_final);
            r_out7 <= r_out6;
        end
    end

    assign m_axis_tvalid = r_v7;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_W){1'b0}}, r_res7};
    assign m_axis_tuser  = r_out7;

    `TGS_ASSERT(a_write_no_result, (adv && wr_en) |=> !r_v1, "write item produced a result")
    `TGS_ASSERT(a_stall_holds, (r_v7 && !m_axis_tready) |=> (r_v6 == $past(r_v6)), "pipe moved in stall")
    `TGS_NEVER(a_pop_in_stall, o_pop && r_v7 && !m_axis_tready, "queue popped while output stalled")

endmodule

// ===== sv/trilinear_grid_sampler.sv =====
// Top level of the trilinear grid sampler: front classifier, queue, back pipeline.
// Depends on tgs_pkg, tgs_front, tgs_queue and tgs_back.
//
// Usage. Items arrive on the slave stream (s_axis_*). tuser selects the kind:
// 0 writes one grid cell (cell index and Q3.20 value), 1 asks for a sample at
// a Q3.20 point in normalized units. Writes give no result. Every query gives
// exactly one result on the master stream (m_axis_*): a Q15.20 distance in
// tdata and, in tuser, a flag that is 1 when the point lies outside the
// interpolable interior and the outside penalty was returned instead.
// Results leave in the order the queries came in, and a query always sees
// every write accepted before it.
// Throughput is one item per cycle unless the output stalls: the grid is split
// into eight banks by index parity, so the eight corners of a cell are read at
// once. A query passes through the queue, whose leaving edge also reads the
// eight banks, then through three multiply and round pairs for the x, y and z
// blends, the last of which loads the output register.
// When the receiver holds tready low with a result waiting, the back pipeline
// freezes, the queue fills, and tready on the slave side drops only once the
// queue is full. Reset clears the queue and the pipeline valid bits; the grid
// contents are not cleared, and each cell must be written before any query
// reads it.
module trilinear_grid_sampler import tgs_pkg::*; #(
    parameter int GRID_N      = GRID_N_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // from bit 0: cell_x[6], cell_y[6], cell_z[6], cell_value[24], coord_x[24],
    // coord_y[24], coord_z[24], zero fill[6]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op: 0 = grid write, 1 = query
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // from bit 0: sample_distance[36], zero fill[4]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // outside flag
    output logic                   m_axis_tuser
);

    t_q_stat q_stat;
    t_cmd    push_cmd, head_cmd;
    logic    push, pop;

    tgs_front #(.GRID_N(GRID_N)) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_stat      (q_stat),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    tgs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_head  (head_cmd)
    );

    tgs_back #(.GRID_N(GRID_N)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_head        (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== verif/trilinear_grid_sampler_test.sv =====
// Self-checking testbench of trilinear_grid_sampler: grid writes, interior and outside queries.
// Depends on tgs_pkg and the trilinear_grid_sampler RTL; a scoreboard class predicts each result.
module trilinear_grid_sampler_test;
    import tgs_pkg::*;

    localparam int     N_CELLS    = 64 * 64 * 64;
    localparam longint ONE_Q      = longint'(1) << 20;
    localparam longint CYCLE_CAP  = 3000000;
    localparam int     RAND_ITEMS = 950;

    typedef struct {
        logic signed [OUT_W-1:0] distance;
        logic                    outside;
    } t_sample;

    // Mirrors the grid and keeps the queue of samples still owed by the block.
    class sample_board;
        int      grid_val [N_CELLS];
        bit      grid_set [N_CELLS];
        t_sample owed [$];
        int      errors;

        function int addr(int x, int y, int z);
            return (z * 64 + y) * 64 + x;
        endfunction

        function longint scaled(logic [COORD_W-1:0] c);
            return longint'($signed(c)) * 64;
        endfunction

        // Truncation toward zero, as an integer cast does.
        function longint cell_of(longint s);
            if (s >= 0) return s >>> 20;
            return -((-s) >>> 20);
        endfunction

        function bit interior(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                              logic [COORD_W-1:0] cz);
            longint ix, iy, iz;
            ix = cell_of(scaled(cx));
            iy = cell_of(scaled(cy));
            iz = cell_of(scaled(cz));
            return ix >= 0 && iy >= 0 && iz >= 0 && ix < 63 && iy < 63 && iz < 63;
        endfunction

        function longint blend(longint a, longint b, longint w);
            return (a * (ONE_Q - w) + b * w + (ONE_Q >>> 1)) >>> 20;
        endfunction

        function longint edge_cost(longint s, longint idx);
            if (idx < 0) return -s;
            if (idx >= 64) return s - (63 * ONE_Q - MILLI_Q20);
            return 0;
        endfunction

        function longint corner(longint x, longint y, longint z);
            return longint'(grid_val[addr(int'(x), int'(y), int'(z))]);
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note(logic kind, logic [IN_TDATA_W-1:0] d);
            longint  sx, sy, sz, ix, iy, iz, wx, wy, wz, acc;
            longint  c00, c10, c01, c11, c0, c1;
            int      a;
            t_sample r;
            if (kind == KIND_WRITE) begin
                a = addr(d[5:0], d[11:6], d[17:12]);
                grid_val[a] = $signed(d[41:18]);
                grid_set[a] = 1'b1;
                return;
            end
            sx = scaled(d[65:42]);
            sy = scaled(d[89:66]);
            sz = scaled(d[113:90]);
            ix = cell_of(sx);
            iy = cell_of(sy);
            iz = cell_of(sz);
            if (interior(d[65:42], d[89:66], d[113:90])) begin
                wx = sx - ix * ONE_Q;
                wy = sy - iy * ONE_Q;
                wz = sz - iz * ONE_Q;
                c00 = blend(corner(ix, iy, iz), corner(ix + 1, iy, iz), wx);
                c10 = blend(corner(ix, iy + 1, iz), corner(ix + 1, iy + 1, iz), wx);
                c01 = blend(corner(ix, iy, iz + 1), corner(ix + 1, iy, iz + 1), wx);
                c11 = blend(corner(ix, iy + 1, iz + 1), corner(ix + 1, iy + 1, iz + 1), wx);
                c0  = blend(c00, c10, wy);
                c1  = blend(c01, c11, wy);
                acc = blend(c0, c1, wz);
                r.outside = 1'b0;
            end else begin
                acc = edge_cost(sx, ix) + edge_cost(sy, iy) + edge_cost(sz, iz);
                r.outside = 1'b1;
            end
            if (acc > (longint'(1) << 35) - 1) acc = (longint'(1) << 35) - 1;
            if (acc < -(longint'(1) << 35)) acc = -(longint'(1) << 35);
            r.distance = acc[OUT_W-1:0];
            owed.push_back(r);
        endfunction

        function void check(logic [OUT_TDATA_W-1:0] d, logic flag);
            t_sample e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected sample %h flag %b", d, flag);
                return;
            end
            e = owed.pop_front();
            if (d[OUT_W-1:0] !== e.distance || d[OUT_TDATA_W-1:OUT_W] !== '0 ||
                flag !== e.outside) begin
                errors++;
                if (errors <= 10)
                    $display("sample mismatch: expected %0d/%b, got %0d/%b",
                             e.distance, e.outside, $signed(d[OUT_W-1:0]), flag);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    sample_board board;
    longint      cycles;
    bit          no_idle;
    bit          held;
    int          rx_hold;
    int          sent;

    trilinear_grid_sampler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("trilinear_grid_sampler_test: errors");
            $finish;
        end
    end

    // Offers one item and waits for the block to take it.
    task automatic push_item(logic kind, logic [IN_TDATA_W-1:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note(kind, d);
        sent++;
    endtask

    task automatic write_cell(int x, int y, int z, logic [VAL_W-1:0] v);
        logic [IN_TDATA_W-1:0] d;
        d = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[IN_TDATA_W-1:114] = '0;
        d[5:0]   = 6'(x);
        d[11:6]  = 6'(y);
        d[17:12] = 6'(z);
        d[41:18] = v;
        push_item(KIND_WRITE, d);
    endtask

    function automatic logic [VAL_W-1:0] some_value();
        case ($urandom_range(0, 5))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // Queries a point; any unwritten corner of an interior cell is loaded first.
    task automatic query_point(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [COORD_W-1:0] cz);
        logic [IN_TDATA_W-1:0] d;
        int ix, iy, iz;
        if (board.interior(cx, cy, cz)) begin
            ix = int'(board.cell_of(board.scaled(cx)));
            iy = int'(board.cell_of(board.scaled(cy)));
            iz = int'(board.cell_of(board.scaled(cz)));
            for (int k = 0; k < 8; k++)
                if (!board.grid_set[board.addr(ix + k[0], iy + k[1], iz + k[2])])
                    write_cell(ix + k[0], iy + k[1], iz + k[2], some_value());
        end
        d = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[IN_TDATA_W-1:114] = '0;
        d[65:42]  = cx;
        d[89:66]  = cy;
        d[113:90] = cz;
        push_item(KIND_QUERY, d);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        int cell_idx;
        case ($urandom_range(0, 9))
            6: return 24'($urandom);
            7: return 24'(32'sd1048576 + $urandom_range(0, 40000) - 20000);
            8: return 24'(-$urandom_range(1, 16383));
            9: return 24'($urandom_range(0, 24'h0FFFFF));
            default: begin
                // Reuse a few cells at both ends of the grid.
                cell_idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(59, 62);
                return 24'(cell_idx * 16384 + $urandom_range(0, 16383));
            end
        endcase
    endfunction

    // Result side: random stalls, bursts with none, and one long hold-off on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            stall = no_idle ? 0 : $urandom_range(0, 12);
            if (rx_hold > 0) begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            board.check(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        board         = new();
        cycles        = 0;
        no_idle       = 1'b0;
        held          = 1'b0;
        rx_hold       = 0;
        sent          = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = KIND_WRITE;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extreme corner values at both ends of the grid.
        for (int k = 0; k < 8; k++) begin
            write_cell(k[0], k[1], k[2], k[0] ? 24'h7FFFFF : 24'h800000);
            write_cell(62 + k[0], 62 + k[1], 62 + k[2], k[1] ? 24'h800000 : 24'h7FFFFF);
        end
        query_point(24'h000000, 24'h000000, 24'h000000);
        // Small negative coordinate: cell zero with a negative weight.
        query_point(24'hFFFFFF, 24'hFFC001, 24'h000001);
        // Last interior cell with the weight just below one.
        query_point(24'h0FBFFF, 24'h0FBFFF, 24'h0FBFFF);
        // Index N-1 contributes nothing; index N and beyond pays the far penalty.
        query_point(24'h0FC000, 24'h000000, 24'h000000);
        query_point(24'h100000, 24'h0FC000, 24'h7FFFFF);
        query_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        query_point(24'h800000, 24'h800000, 24'h800000);
        query_point(24'hF00000, 24'h000000, 24'h7FFFFF);

        // Random part, with one burst stretch and two pressure episodes.
        while (sent < RAND_ITEMS + 40) begin
            if (sent > 300 && sent < 400) no_idle = 1'b1;
            else no_idle = 1'b0;
            if (!held && sent >= 500) begin
                // Hold results off while items keep coming, so the queue fills.
                held    = 1'b1;
                rx_hold = 400;
                no_idle = 1'b1;
                repeat (60) query_point(pick_coord(), pick_coord(), pick_coord());
            end
            if (sent > 700 && sent < 710) begin
                // Sender pauses until every owed sample has been delivered.
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) == 0)
                write_cell($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 63), some_value());
            else
                query_point(pick_coord(), pick_coord(), pick_coord());
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("trilinear_grid_sampler_test: clean");
        end else begin
            $display("trilinear_grid_sampler_test: errors");
        end
        $finish;
    end

endmodule
